### src/lca_pkg.sv
package lca_pkg;

	localparam int DEF_MAX_COLS = 512;
	localparam int DEF_MAX_ROWS = 512;
	localparam int DIM_W        = 10;
	localparam int DIM_RESET    = 512;
	localparam int FIELD_W      = 9;
	localparam int CFG_IDX_W    = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_WIDTH  = 1'b0,
		CFG_GRID_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic               emit;
		logic               inner;
		logic [FIELD_W-1:0] row;
		logic [FIELD_W-1:0] col;
		logic               done;
		logic               cur;
	} lca_item_t;

	function automatic logic life_rule(input logic [8:0] win);
		logic [3:0] sum;
		logic [7:0] nbr;
		sum = 4'd0;
		nbr = {win[8:5], win[3:0]};
		for (int i = 0; i < 8; i++) begin
			sum = sum + 4'(nbr[i]);
		end
		if (win[4]) begin
			return (sum == 4'd2) || (sum == 4'd3);
		end
		return sum == 4'd3;
	endfunction

endpackage

### src/lca_if.sv
interface lca_in_if;
	logic valid;
	logic ready;
	logic cell_alive;

	modport source (output valid, output cell_alive, input ready);
	modport sink (input valid, input cell_alive, output ready);
endinterface

interface lca_out_if;
	logic                        valid;
	logic                        ready;
	logic                        next_alive;
	logic [lca_pkg::FIELD_W-1:0] out_row;
	logic [lca_pkg::FIELD_W-1:0] out_col;
	logic                        frame_done;

	modport source (output valid, output next_alive, output out_row, output out_col,
		output frame_done, input ready);
	modport sink (input valid, input next_alive, input out_row, input out_col,
		input frame_done, output ready);
endinterface

### src/lca_line_mem.sv
module lca_line_mem #(
	parameter int DEPTH = lca_pkg::DEF_MAX_COLS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [1:0]    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [1:0]    wr_data,
	output logic          busy
);
	import lca_pkg::*;

	logic [1:0]    mem_q [DEPTH];
	logic [1:0]    rd_data_q;
	logic [AW-1:0] clr_q;
	logic          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (clr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem_q[clr_q] <= 2'b00;
		end else if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

### src/lca_window.sv
module lca_window (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  lca_pkg::lca_item_t item,
	input  logic [1:0]         lines,
	output logic               alive
);
	import lca_pkg::*;

	logic [8:0] win_q;
	logic [8:0] win_nxt;

	// Newest column enters at the top: upper, middle, then the arriving cell.
	assign win_nxt = {item.cur, lines[1], lines[0], win_q[8:3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (adv) begin
			win_q <= win_nxt;
		end
	end

	assign alive = item.inner ? life_rule(win_nxt) : 1'b0;

endmodule

### src/life_cellular_automaton_step.sv
// Result path: an accepted cell is held in the stage-1 register, then its result enters the
// output register that drives cell_out.valid. Throughput: one cell per cycle while cell_out
// is not back-pressured, set by the line store, which is read once and written once per cycle at the column address.
// Reset: counters, window and handshakes clear at once; the line store then clears its
// MAX_COLS entries one after another, during which cell_in.ready stays low.
module life_cellular_automaton_step #(
	parameter int MAX_COLS = lca_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = lca_pkg::DEF_MAX_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lca_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [lca_pkg::DIM_W-1:0]     cfg_wdata,
	lca_in_if.sink                        cell_in,
	lca_out_if.source                     cell_out
);
	import lca_pkg::*;

	localparam int CW    = $clog2(MAX_COLS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int MAXD  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
	localparam int LW    = (($clog2(MAXD + 1) > DIM_W) ? $clog2(MAXD + 1) : DIM_W) + 1;
	localparam int W_RST = ((DIM_RESET > MAX_COLS) ? MAX_COLS : DIM_RESET) - 1;
	localparam int H_RST = ((DIM_RESET > MAX_ROWS) ? MAX_ROWS : DIM_RESET) - 1;

	logic [LW-1:0] w_last_q, h_last_q;
	logic [LW-1:0] cfg_val, w_lim, h_lim;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          last_col, last_row, accept, busy;

	logic          valid_s1;
	lca_item_t     item_s1;
	logic [CW-1:0] addr_s1;
	logic          fire_s1;
	logic [1:0]    lines;
	logic          alive;

	logic               out_valid_q;
	logic               next_alive_q;
	logic [FIELD_W-1:0] out_row_q, out_col_q;
	logic               frame_done_q;

	assign cfg_val = LW'(cfg_wdata);
	assign w_lim   = (cfg_val < LW'(3)) ? LW'(3) :
		(cfg_val > LW'(MAX_COLS)) ? LW'(MAX_COLS) : cfg_val;
	assign h_lim   = (cfg_val < LW'(3)) ? LW'(3) :
		(cfg_val > LW'(MAX_ROWS)) ? LW'(MAX_ROWS) : cfg_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= LW'(W_RST);
			h_last_q <= LW'(H_RST);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				CFG_GRID_WIDTH:  w_last_q <= w_lim - 1'b1;
				CFG_GRID_HEIGHT: h_last_q <= h_lim - 1'b1;
				default: ;
			endcase
		end
	end

	assign last_col = LW'(col_q) >= w_last_q;
	assign last_row = LW'(row_q) >= h_last_q;

	assign fire_s1      = valid_s1 && (!item_s1.emit || !out_valid_q || cell_out.ready);
	assign cell_in.ready = !busy && (!valid_s1 || fire_s1);
	assign accept       = cell_in.valid && cell_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.emit  <= (row_q != '0) && (col_q != '0);
			item_s1.inner <= (row_q >= RW'(2)) && (col_q >= CW'(2));
			item_s1.row   <= FIELD_W'(row_q - 1'b1);
			item_s1.col   <= FIELD_W'(col_q - 1'b1);
			item_s1.done  <= last_row && last_col;
			item_s1.cur   <= cell_in.cell_alive;
			addr_s1       <= col_q;
		end
	end

	lca_line_mem #(
		.DEPTH (MAX_COLS),
		.AW    (CW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (lines),
		.wr_en   (fire_s1),
		.wr_addr (addr_s1),
		.wr_data ({item_s1.cur, lines[1]}),
		.busy    (busy)
	);

	lca_window u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (fire_s1),
		.item   (item_s1),
		.lines  (lines),
		.alive  (alive)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && item_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (cell_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && item_s1.emit) begin
			next_alive_q <= alive;
			out_row_q    <= item_s1.row;
			out_col_q    <= item_s1.col;
			frame_done_q <= item_s1.done;
		end
	end

	assign cell_out.valid      = out_valid_q;
	assign cell_out.next_alive = next_alive_q;
	assign cell_out.out_row    = out_row_q;
	assign cell_out.out_col    = out_col_q;
	assign cell_out.frame_done = frame_done_q;

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cell_in.ready)
		else $error("cell accepted during line store clear");

	a_emit_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && item_s1.emit) |=> out_valid_q)
		else $error("emitted result did not reach the output register");

	a_border_dead: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_row_q == '0 || out_col_q == '0)) |-> !next_alive_q)
		else $error("border cell emitted alive");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_col && last_row) |=> (col_q == '0 && row_q == '0))
		else $error("counters did not wrap at the end of the generation");

endmodule
